>>> hdl/edge_word_subword_search_core_macros.svh
// assertion macros for the edge word subword search core
`ifndef EDGE_WORD_SUBWORD_SEARCH_CORE_MACROS_SVH
`define EDGE_WORD_SUBWORD_SEARCH_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define EWSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define EWSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define EWSS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EWSS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/ewss_pkg.sv
// shared constants and types of the edge word subword search core
package ewss_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int WORD_MAX    = 65536;
    localparam int EDGE_BITS   = 32;

    localparam int POS_W  = 16;
    localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
    localparam int CNT_W  = $clog2(WORD_MAX + 2);
    localparam int CMP_W  = (CNT_W > PLEN_W) ? CNT_W : PLEN_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0]
    {
        CMD_LOAD_FIRST,
        CMD_LOAD_NEXT,
        CMD_WORD,
        CMD_WORD_END
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t              kind;
        logic [EDGE_BITS-1:0]   edge_id;
    } cmd_t;

    typedef struct packed
    {
        logic [QCNT_W-1:0]  count;
        logic               full;
        logic               empty;
    } q_status_t;

endpackage

>>> hdl/ewss_if.sv
// valid/ready channel interfaces of the edge word subword search core
interface ewss_in_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [ewss_pkg::EDGE_BITS-1:0] edge_req;
    logic                           last;

    modport source (output valid, output operation, output edge_req, output last,
                    input ready);
    modport sink   (input valid, input operation, input edge_req, input last,
                    output ready);
endinterface

interface ewss_out_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [ewss_pkg::POS_W-1:0] position;
    logic                       overflow;

    modport source (output valid, output found, output position, output overflow,
                    input ready);
    modport sink   (input valid, input found, input position, input overflow,
                    output ready);
endinterface

interface ewss_cmd_if;
    logic             valid;
    logic             ready;
    ewss_pkg::cmd_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/edge_word_subword_search_core.sv
// top level of the edge word subword search core
//
// Finds the first place where a pattern of edge ids occurs as a contiguous
// run in a word of edge ids. Items arrive on req: operation 0 loads a pattern
// element, operation 1 feeds a word element, last closes the pattern or the
// word. A load that follows a closed pattern starts a new one. Up to 16
// pattern elements are kept; more set overflow and the pattern never
// matches. Each word element shifts a 16-entry window that is compared
// against the pattern in all lanes at once; word elements past 65536 take no
// part in matching and set overflow. Only the word's last element produces a
// transfer on rsp, carrying found, the zero-based start position (0 if not
// found) and overflow. Every item passes through the back end once, so
// the block sustains one transfer per clock on req while rsp takes its
// results; a result reaches rsp through the front register, the two-entry
// command queue and the result register. The block keeps taking items while
// a result waits on rsp until the queue and the front register fill. No
// clearing pass is needed after reset.
module edge_word_subword_search_core
(
    input  logic         clk,
    input  logic         rst_n,
    ewss_in_if.sink      req,
    ewss_out_if.source   rsp
);
    import ewss_pkg::*;

    `include "edge_word_subword_search_core_macros.svh"

    // front to queue, and queue to back command channels
    ewss_cmd_if  cmd_ch ();
    ewss_cmd_if  qout_ch ();
    q_status_t   q_stat;
    logic        back_word_end;

    ewss_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd_ch.source)
    );

    ewss_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_ch (cmd_ch.sink),
        .pop_ch  (qout_ch.source),
        .status  (q_stat)
    );

    ewss_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (qout_ch.sink),
        .rsp   (rsp)
    );

    // closing word element taken by the back end this cycle
    assign back_word_end = qout_ch.valid && qout_ch.ready
                           && (qout_ch.payload.kind == CMD_WORD_END);

    // an accepted item is always held by the front register on the next cycle
    `EWSS_ASSERT_NXT(a_front_holds, clk, rst_n, req.valid && req.ready, cmd_ch.valid)

    // the back end never pulls from an empty queue
    `EWSS_ASSERT_IMP(a_pop_nonempty, clk, rst_n, qout_ch.valid && qout_ch.ready, !q_stat.empty)

    // a result appears only after a closing word element reached the back end
    `EWSS_ASSERT_IMP(a_result_source, clk, rst_n, $rose(rsp.valid), $past(back_word_end))

endmodule

>>> hdl/ewss_front.sv
// front end: accepts items, tracks pattern framing and issues commands
module ewss_front
(
    input  logic         clk,
    input  logic         rst_n,
    ewss_in_if.sink      req,
    ewss_cmd_if.source   cmd
);
    import ewss_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    cmd_t   cmd_reg;
    cmd_t   cmd_next;
    logic   open_reg;
    logic   open_next;
    logic   take;

    always_comb
    begin
        req.ready  = !valid_reg || cmd.ready;
        take       = req.valid && req.ready;
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        open_next  = open_reg;
        if (take)
        begin
            valid_next       = 1'b1;
            cmd_next.edge_id = req.edge_req;
            if (req.operation)
            begin
                cmd_next.kind = req.last ? CMD_WORD_END : CMD_WORD;
            end
            else
            begin
                // a load while no pattern is open starts a fresh pattern
                cmd_next.kind = open_reg ? CMD_LOAD_NEXT : CMD_LOAD_FIRST;
                open_next     = !req.last;
            end
        end
        else if (cmd.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            open_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            open_reg  <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd.valid   = valid_reg;
    assign cmd.payload = cmd_reg;

endmodule

>>> hdl/ewss_queue.sv
// short command queue between front and back
module ewss_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    ewss_cmd_if.sink             push_ch,
    ewss_cmd_if.source           pop_ch,
    output ewss_pkg::q_status_t  status
);
    import ewss_pkg::*;

    cmd_t               mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    logic               pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + QPTR_W'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        status.count   = count_reg;
        status.full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
        status.empty   = (count_reg == '0);
        push_ch.ready  = !status.full;
        pop_ch.valid   = !status.empty;
        pop_ch.payload = mem[rd_ptr_reg];
        push           = push_ch.valid && push_ch.ready;
        pop            = pop_ch.valid && pop_ch.ready;
        wr_ptr_next    = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next    = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next     = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_ch.payload;
        end
    end

endmodule

>>> hdl/ewss_back.sv
// back end: pattern shift line, word window, parallel compare and result register
module ewss_back
(
    input  logic         clk,
    input  logic         rst_n,
    ewss_cmd_if.sink     cmd,
    ewss_out_if.source   rsp
);
    import ewss_pkg::*;

    // pattern held newest-first so that entry j lines up with window entry j
    logic [EDGE_BITS-1:0]   pat_reg  [PATTERN_MAX];
    logic [EDGE_BITS-1:0]   pat_next [PATTERN_MAX];
    logic [EDGE_BITS-1:0]   win_reg  [PATTERN_MAX];
    logic [EDGE_BITS-1:0]   win_next [PATTERN_MAX];
    logic [PLEN_W-1:0]      plen_reg;
    logic [PLEN_W-1:0]      plen_next;
    logic                   too_long_reg;
    logic                   too_long_next;
    logic [CNT_W-1:0]       wc_reg;
    logic [CNT_W-1:0]       wc_next;
    logic [CNT_W-1:0]       wc_inc;
    logic                   seen_reg;
    logic                   seen_next;
    logic [POS_W-1:0]       start_reg;
    logic [POS_W-1:0]       start_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   found_reg;
    logic                   found_next;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic [PATTERN_MAX-1:0] lane_ok;
    logic                   fire;
    logic                   is_word;
    logic                   in_range;
    logic                   hit_now;
    logic [CMP_W-1:0]       wc_cmp;
    logic [CMP_W-1:0]       plen_cmp;

    always_comb
    begin
        cmd.ready = !out_valid_reg || rsp.ready;
        fire      = cmd.valid && cmd.ready;
        is_word   = (cmd.payload.kind == CMD_WORD) || (cmd.payload.kind == CMD_WORD_END);

        win_next[0] = cmd.payload.edge_id;
        pat_next[0] = cmd.payload.edge_id;
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            win_next[k] = win_reg[k-1];
            pat_next[k] = pat_reg[k-1];
        end

        // one comparator per lane, lanes past the pattern length always pass
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            lane_ok[j] = (PLEN_W'(j) >= plen_reg) || (win_next[j] == pat_reg[j]);
        end

        wc_inc   = (wc_reg <= CNT_W'(WORD_MAX)) ? wc_reg + CNT_W'(1) : wc_reg;
        in_range = (wc_inc <= CNT_W'(WORD_MAX));
        wc_cmp   = CMP_W'(wc_inc);
        plen_cmp = CMP_W'(plen_reg);
        hit_now  = in_range && !seen_reg && !too_long_reg && (wc_cmp >= plen_cmp)
                   && (plen_reg != '0) && (&lane_ok);

        plen_next      = plen_reg;
        too_long_next  = too_long_reg;
        wc_next        = wc_reg;
        seen_next      = seen_reg;
        start_next     = start_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        ovf_next       = ovf_reg;
        out_valid_next = rsp.ready ? 1'b0 : out_valid_reg;

        if (fire)
        begin
            case (cmd.payload.kind)
                CMD_LOAD_FIRST:
                begin
                    plen_next     = PLEN_W'(1);
                    too_long_next = 1'b0;
                end
                CMD_LOAD_NEXT:
                begin
                    if (plen_reg < PLEN_W'(PATTERN_MAX))
                    begin
                        plen_next = plen_reg + PLEN_W'(1);
                    end
                    else
                    begin
                        too_long_next = 1'b1;
                    end
                end
                CMD_WORD, CMD_WORD_END:
                begin
                    wc_next = wc_inc;
                    if (hit_now)
                    begin
                        seen_next  = 1'b1;
                        start_next = POS_W'(wc_cmp - plen_cmp);
                    end
                    if (cmd.payload.kind == CMD_WORD_END)
                    begin
                        out_valid_next = 1'b1;
                        found_next     = seen_next && !too_long_reg;
                        pos_next       = found_next ? start_next : '0;
                        ovf_next       = too_long_reg || !in_range;
                        wc_next        = '0;
                        seen_next      = 1'b0;
                        start_next     = '0;
                    end
                end
                default:
                begin
                    plen_next = plen_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            too_long_reg  <= 1'b0;
            wc_reg        <= '0;
            seen_reg      <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            plen_reg      <= plen_next;
            too_long_reg  <= too_long_next;
            wc_reg        <= wc_next;
            seen_reg      <= seen_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        pos_reg   <= pos_next;
        ovf_reg   <= ovf_next;
        if (fire && is_word)
        begin
            win_reg <= win_next;
        end
        // loads past capacity are dropped
        if (fire && ((cmd.payload.kind == CMD_LOAD_FIRST)
            || ((cmd.payload.kind == CMD_LOAD_NEXT) && (plen_reg < PLEN_W'(PATTERN_MAX)))))
        begin
            pat_reg <= pat_next;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.found    = found_reg;
    assign rsp.position = pos_reg;
    assign rsp.overflow = ovf_reg;

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the edge word subword search core
`timescale 1ns / 1ps

module tb_top;

    import ewss_pkg::*;

    // what an item on req asks the block to do
    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_WORD = 1'b1
    } edge_op_t;

    // one item waiting to go out on req
    typedef struct
    {
        edge_op_t               op;
        logic [EDGE_BITS-1:0]   edge_id;
        logic                   lst;
        bit                     drain_first;
    } edge_item_t;

    // one search outcome as it should appear on rsp
    typedef struct packed
    {
        logic               found;
        logic [POS_W-1:0]   position;
        logic               overflow;
    } search_result_t;

    localparam int RANDOM_ITEMS = 500;
    localparam int MAX_GAP      = 4;
    localparam int LONG_HOLD    = 60;     // receiver hold-off that backs up the block
    localparam int HOLD_AT      = 40;     // result count at which the hold-off starts
    localparam int QUIET_LIMIT  = 1000;   // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES = 20;     // settling margin after the last outcome before the summary

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    ewss_in_if  req_if();
    ewss_out_if rsp_if();

    edge_word_subword_search_core DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // stimulus not yet offered, and search outcomes not yet seen on rsp
    edge_item_t         pending_edges[$];
    search_result_t     awaited_results[$];
    logic [EDGE_BITS-1:0] cur_pattern[$];
    bit                 drain_next = 1'b0;

    int sent_items      = 0;
    int results_checked = 0;
    int hits_seen       = 0;
    int overflows_seen  = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;

    // ------------------------------------------------------------------
    // search predictor: its own copy of the pattern store and the window
    // ------------------------------------------------------------------
    logic [EDGE_BITS-1:0] pat_mem[PATTERN_MAX];
    logic [EDGE_BITS-1:0] win[PATTERN_MAX] = '{default: '0};
    int  pat_len      = 0;
    bit  pat_open     = 1'b0;
    bit  pat_overflow = 1'b0;
    int  word_cnt     = 0;
    bit  hit_seen     = 1'b0;
    int  hit_start    = 0;

    // newest pat_len window entries against the pattern, oldest first
    function automatic bit window_hit();
        if (pat_len == 0)
            return 1'b0;
        for (int k = 0; k < pat_len; k++)
        begin
            if (win[pat_len - 1 - k] !== pat_mem[k])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // advance the predictor by one accepted item, queue an outcome on word end
    function automatic void search_step(edge_op_t op, logic [EDGE_BITS-1:0] e, logic lst);
        search_result_t res;
        if (op == OP_LOAD)
        begin
            // a load after a closed pattern starts a fresh one
            if (!pat_open)
            begin
                pat_len      = 0;
                pat_overflow = 1'b0;
            end
            // elements past the store are dropped and poison the pattern
            if (pat_len < PATTERN_MAX)
            begin
                pat_mem[pat_len] = e;
                pat_len++;
            end
            else
                pat_overflow = 1'b1;
            pat_open = !lst;
            return;
        end
        for (int k = PATTERN_MAX - 1; k > 0; k--)
            win[k] = win[k - 1];
        win[0] = e;
        // count saturates one past the word limit
        if (word_cnt <= WORD_MAX)
            word_cnt++;
        // only the first occurrence inside the word limit counts
        if (word_cnt <= WORD_MAX && !hit_seen && !pat_overflow &&
            word_cnt >= pat_len && window_hit())
        begin
            hit_seen  = 1'b1;
            hit_start = word_cnt - pat_len;
        end
        if (!lst)
            return;
        res.found    = hit_seen && !pat_overflow;
        res.position = res.found ? POS_W'(hit_start) : '0;
        res.overflow = pat_overflow || (word_cnt > WORD_MAX);
        awaited_results.push_back(res);
        // word end clears the window side, the pattern stays
        win       = '{default: '0};
        word_cnt  = 0;
        hit_seen  = 1'b0;
        hit_start = 0;
    endfunction

    // ------------------------------------------------------------------
    // req driver: offers queued items, random gaps between transfers
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin : req_drive
        edge_item_t nxt;
        bit         busy;
        if (!rst_n)
        begin
            req_if.valid     <= 1'b0;
            req_if.operation <= OP_LOAD;
            req_if.edge_req  <= '0;
            req_if.last      <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            busy = req_if.valid && !req_if.ready;
            if (req_if.valid && req_if.ready)
            begin
                search_step(edge_op_t'(req_if.operation), req_if.edge_req, req_if.last);
                sent_items++;
                // gaps in half of every 128 items, back to back in the other half
                send_gap = ((sent_items % 128) < 64) ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (!busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (pending_edges.size() > 0 &&
                         (!pending_edges[0].drain_first || awaited_results.size() == 0))
                begin
                    // a marked item waits until every outcome has come back
                    nxt = pending_edges.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.operation <= nxt.op;
                    req_if.edge_req  <= nxt.edge_id;
                    req_if.last      <= nxt.lst;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // rsp monitor: random stalls, one long hold-off, field by field check
    // ------------------------------------------------------------------
    int rsp_stall = 0;

    always @(posedge clk or negedge rst_n)
    begin : rsp_check
        search_result_t want;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rsp_stall = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: found %0d position %0d overflow %0d",
                           rsp_if.found, rsp_if.position, rsp_if.overflow);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_if.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, rsp_if.found);
                        mismatches++;
                    end
                    if (rsp_if.position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d",
                               want.position, rsp_if.position);
                        mismatches++;
                    end
                    if (rsp_if.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d",
                               want.overflow, rsp_if.overflow);
                        mismatches++;
                    end
                    hits_seen      += want.found;
                    overflows_seen += want.overflow;
                end
                results_checked++;
                // stalls in half of every 32 results
                rsp_stall = ((results_checked % 32) < 16) ? $urandom_range(0, MAX_GAP) : 0;
                // long hold-off while the driver keeps offering, fills the block
                if (results_checked == HOLD_AT)
                    rsp_stall = LONG_HOLD;
            end
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // cycles since the last transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("tb_top: no transfer for %0d cycles, %0d outcomes outstanding",
                 QUIET_LIMIT, awaited_results.size());
        $display("tb_top: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    task automatic push_edge(input edge_op_t op, input logic [EDGE_BITS-1:0] e,
                             input logic lst);
        edge_item_t it;
        it.op          = op;
        it.edge_id     = e;
        it.lst         = lst;
        it.drain_first = drain_next;
        drain_next     = 1'b0;
        pending_edges.push_back(it);
    endtask

    // narrow values collide often and give partial matches
    function automatic logic [EDGE_BITS-1:0] pick_edge(bit narrow);
        return narrow ? EDGE_BITS'($urandom_range(0, 3)) : EDGE_BITS'($urandom);
    endfunction

    task automatic push_pattern();
        for (int i = 0; i < cur_pattern.size(); i++)
            push_edge(OP_LOAD, cur_pattern[i], i == cur_pattern.size() - 1);
    endtask

    // word of wlen elements, with the current pattern planted at plant_at if >= 0
    task automatic push_word(input int wlen, input int plant_at, input bit narrow);
        logic [EDGE_BITS-1:0] v;
        for (int i = 0; i < wlen; i++)
        begin
            if (plant_at >= 0 && i >= plant_at && i < plant_at + cur_pattern.size())
                v = cur_pattern[i - plant_at];
            else
                v = pick_edge(narrow);
            push_edge(OP_WORD, v, i == wlen - 1);
        end
    endtask

    initial
    begin : main_seq
        int  made;
        int  plen;
        int  wlen;
        int  roll;
        bit  narrow;

        // directed: no pattern loaded yet, nothing can match
        push_edge(OP_WORD, 32'd5, 1'b1);
        // extreme edge values, match in the middle
        cur_pattern = '{32'hFFFF_FFFF, 32'h0};
        push_pattern();
        push_edge(OP_WORD, 32'h0, 1'b0);
        push_edge(OP_WORD, 32'hFFFF_FFFF, 1'b0);
        push_edge(OP_WORD, 32'h0, 1'b1);
        // single element pattern and word
        cur_pattern = '{32'd7};
        push_pattern();
        push_edge(OP_WORD, 32'd7, 1'b1);
        // match at the very end of the word, then a miss
        cur_pattern = '{32'd1, 32'd2};
        push_pattern();
        push_edge(OP_WORD, 32'd3, 1'b0);
        push_edge(OP_WORD, 32'd3, 1'b0);
        push_edge(OP_WORD, 32'd1, 1'b0);
        push_edge(OP_WORD, 32'd2, 1'b1);
        push_edge(OP_WORD, 32'd2, 1'b0);
        push_edge(OP_WORD, 32'd1, 1'b1);
        // word against a pattern still open, then the pattern grows
        push_edge(OP_LOAD, 32'd9, 1'b0);
        push_edge(OP_WORD, 32'd9, 1'b1);
        push_edge(OP_LOAD, 32'd8, 1'b1);
        push_edge(OP_WORD, 32'd9, 1'b0);
        push_edge(OP_WORD, 32'd8, 1'b1);
        // new pattern loaded in the middle of a word
        push_edge(OP_LOAD, 32'd4, 1'b1);
        push_edge(OP_WORD, 32'd1, 1'b0);
        push_edge(OP_LOAD, 32'd5, 1'b1);
        push_edge(OP_WORD, 32'd5, 1'b1);

        // random: mostly pattern then words, some loose items
        drain_next = 1'b1;
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                narrow = $urandom_range(0, 9) < 7;
                roll   = $urandom_range(0, 19);
                if (roll < 14)
                    plen = $urandom_range(1, 4);
                else if (roll < 17)
                    plen = $urandom_range(5, PATTERN_MAX);
                else
                    plen = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 4);
                cur_pattern.delete();
                repeat (plen)
                    cur_pattern.push_back(pick_edge(narrow));
                push_pattern();
                made += plen;
                repeat ($urandom_range(1, 4))
                begin
                    wlen = $urandom_range(1, 12);
                    if ($urandom_range(0, 9) < 6)
                    begin
                        if (wlen < plen)
                            wlen = plen + $urandom_range(0, 3);
                        push_word(wlen, $urandom_range(0, wlen - plen), narrow);
                    end
                    else
                        push_word(wlen, -1, narrow);
                    made += wlen;
                end
            end
            else
            begin
                // loose items: open patterns, reloads, odd last marks
                repeat ($urandom_range(1, 6))
                begin
                    push_edge(edge_op_t'($urandom_range(0, 1)),
                              pick_edge($urandom_range(0, 1)), $urandom_range(0, 1));
                    made++;
                end
            end
        end

        // hold reset, then release it away from the rising edge
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_edges.size() != 0 || req_if.valid !== 1'b0 ||
               awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d items sent, %0d searches checked, %0d found, %0d overflow",
                 sent_items, results_checked, hits_seen, overflows_seen);
        $display("tb_top: %0d field mismatches", mismatches);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/ewss_pkg.sv
hdl/ewss_if.sv
hdl/ewss_front.sv
hdl/ewss_queue.sv
hdl/ewss_back.sv
hdl/edge_word_subword_search_core.sv
verif/tb_top.sv
